FILE: hdl/tal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tal_pkg: shared types and constants of the thermistor average/linearizer
// widths, fixed-point formats, polynomial coefficients and word layouts
// ----------------------------------------------------------------------------
package tal_pkg;

	// window depth default, handed to the top level parameter
	localparam int WINDOW_DEF = 60;

	localparam int SAMPLE_W = 10;
	localparam int SUM_W    = 16;
	localparam int VOLT_W   = 19;
	localparam int FRAC_W   = 16;
	localparam int ACC_W    = 36;
	localparam int TEMP_W   = 12;
	localparam int DIGIT_W  = 4;

	// reciprocal divide of the running sum by the window
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	// volts = floor(avg * 5 * 2^16 / 1023) = y + floor(y / 1023), y = 320 * avg
	localparam int VOLT_SCALE       = 320;
	localparam int VOLT_DIV         = 1023;
	localparam int VOLT_RECIP_SHIFT = 29;
	localparam int VOLT_RECIP_W     = 20;
	localparam int VOLT_RECIP       = (1 << VOLT_RECIP_SHIFT) / VOLT_DIV;
	localparam int VOLT_Q_W         = 10;

	// temperature range and display window, tenths of a degree
	localparam int TENTHS_MIN = -1000;
	localparam int TENTHS_MAX = 2000;
	localparam int DISP_MAX   = 999;

	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam int POLY_DEG = 6;

	// signed Q16.16 coefficients, c0 first
	localparam acc_t POLY_COEF [POLY_DEG+1] = '{
		ACC_W'(8675656),
		ACC_W'(-12153651),
		ACC_W'(11027087),
		ACC_W'(-5790171),
		ACC_W'(1631715),
		ACC_W'(-230870),
		ACC_W'(12707)
	};

	typedef struct packed {
		logic [SAMPLE_W-1:0] adc_sample;
	} adc_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]      averaged_sample;
		logic signed [TEMP_W-1:0] temp_tenths;
		logic [DIGIT_W-1:0]       tens_digit;
		logic [DIGIT_W-1:0]       units_digit;
		logic [DIGIT_W-1:0]       tenths_digit;
		logic                     display_clamped;
	} temp_word_t;

	// job handed from the averaging front to the polynomial back
	typedef struct packed {
		logic [SAMPLE_W-1:0] avg;
		logic [VOLT_W-1:0]   volts;
	} tal_job_t;

endpackage
`default_nettype wire

FILE: hdl/tal_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tal_stream_if: valid/ready channel
// carries one word per handshake, payload type set per instance
// ----------------------------------------------------------------------------
interface tal_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/tal_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tal_front: sample window and scaling
// keeps the sample ring and running sum, forms the average and the volts value
// ----------------------------------------------------------------------------
module tal_front #(
	parameter int WINDOW = tal_pkg::WINDOW_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	tal_stream_if.sink        adc,
	output logic              job_valid,
	output tal_pkg::tal_job_t job,
	input  wire logic         queue_full
);
	import tal_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int WIN_W  = $clog2(WINDOW + 1);
	localparam int QW_W   = SUM_W + WIN_W;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int VPROD_W = VOLT_W + VOLT_RECIP_W;
	localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW - 1);
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((1 << RECIP_SHIFT) / WINDOW);
	localparam logic [SAMPLE_W-1:0] AVG_MAX  = '1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_AVG  = 3'd4;
	localparam logic [2:0] ST_VMUL = 3'd5;
	localparam logic [2:0] ST_VOLT = 3'd6;
	localparam logic [2:0] ST_PUSH = 3'd7;

	logic [2:0]          state_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] ring_rd_q;
	logic [SAMPLE_W-1:0] ring_mem [WINDOW];
	logic [WINDOW-1:0]   ring_vld_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [VPROD_W-1:0]  vprod_q;
	tal_job_t            job_q;

	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    q_est;
	logic [QW_W-1:0]     q_w;
	logic [QW_W-1:0]     q_rem;
	logic [SUM_W-1:0]    q_fix;
	logic [SAMPLE_W-1:0] avg_next;
	logic [VOLT_W-1:0]   y_scaled;
	logic [VOLT_Q_W-1:0] vq_est;
	logic [VOLT_W-1:0]   vq_rem;
	logic [VOLT_Q_W-1:0] vq_fix;
	logic [VOLT_W-1:0]   volts_next;

	assign adc.ready = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_PUSH);
	assign job       = job_q;

	// an entry never written since reset reads as zero
	assign old_sample = ring_vld_q[slot_q] ? ring_rd_q : '0;

	// sum / WINDOW by reciprocal, estimate low by at most one
	always_comb begin
		q_est = prod_q[RECIP_SHIFT +: SUM_W];
		q_w   = QW_W'(q_est) * QW_W'(WINDOW);
		q_rem = QW_W'(sum_q) - q_w;
		q_fix = (q_rem >= QW_W'(WINDOW)) ? q_est + 1'b1 : q_est;
		avg_next = (q_fix > SUM_W'(AVG_MAX)) ? AVG_MAX : q_fix[SAMPLE_W-1:0];
	end

	// y / 1023 by reciprocal, same one-step correction
	always_comb begin
		y_scaled   = VOLT_W'(avg_q) * VOLT_W'(VOLT_SCALE);
		vq_est     = vprod_q[VOLT_RECIP_SHIFT +: VOLT_Q_W];
		vq_rem     = y_scaled - VOLT_W'(vq_est) * VOLT_W'(VOLT_DIV);
		vq_fix     = (vq_rem >= VOLT_W'(VOLT_DIV)) ? vq_est + 1'b1 : vq_est;
		volts_next = y_scaled + VOLT_W'(vq_fix);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && adc.valid) begin
			ring_rd_q <= ring_mem[slot_q];
		end
		if (state_q == ST_SUM) begin
			ring_mem[slot_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ring_vld_q <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (adc.valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					sum_q              <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
					ring_vld_q[slot_q] <= 1'b1;
					slot_q             <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
					state_q            <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_AVG;
				ST_AVG:  state_q <= ST_VMUL;
				ST_VMUL: state_q <= ST_VOLT;
				ST_VOLT: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (!queue_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && adc.valid) begin
			sample_q <= adc.data.adc_sample;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
		end
		if (state_q == ST_AVG) begin
			avg_q <= avg_next;
		end
		if (state_q == ST_VMUL) begin
			vprod_q <= VPROD_W'(y_scaled) * VPROD_W'(VOLT_RECIP);
		end
		if (state_q == ST_VOLT) begin
			job_q.avg   <= avg_q;
			job_q.volts <= volts_next;
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(slot_q) < WINDOW)
		else $error("write slot beyond window");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sum_q) <= WINDOW * ((1 << SAMPLE_W) - 1))
		else $error("running sum exceeds window of full-scale samples");

endmodule
`default_nettype wire

FILE: hdl/tal_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tal_queue: job queue between front and back
// small register fifo so either side can stall on its own
// ----------------------------------------------------------------------------
module tal_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  tal_pkg::tal_job_t push_job,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output tal_pkg::tal_job_t head
);
	import tal_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	tal_job_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= QUEUE_DEPTH)
		else $error("queue count above depth");

endmodule
`default_nettype wire

FILE: hdl/tal_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tal_back: polynomial linearizer and digit split
// horner over one shared multiplier, then tenths, saturation and digits
// ----------------------------------------------------------------------------
module tal_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         job_ready,
	input  tal_pkg::tal_job_t job,
	output logic              job_pop,
	tal_stream_if.source      temp
);
	import tal_pkg::*;

	localparam int MPROD_W = ACC_W + VOLT_W + 1;
	localparam int TEN_W   = ACC_W + 4;
	localparam int HUND_W  = 16;
	localparam int REM_W   = 7;
	localparam int TENS_W  = 15;
	localparam int CLAMP_W = 10;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_TENTH = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	logic [2:0]                state_q;
	logic [2:0]                k_q;
	logic [SAMPLE_W-1:0]       avg_q;
	logic [VOLT_W-1:0]         volts_q;
	acc_t                      acc_q;
	logic signed [MPROD_W-1:0] prod_q;
	logic signed [TEMP_W-1:0]  tenths_q;
	temp_word_t                res_q;
	logic                      res_valid_q;

	logic signed [TEN_W-1:0]   acc_ext;
	logic signed [TEN_W-1:0]   x10;
	logic signed [TEN_W-1:0]   x10_biased;
	logic signed [TEN_W-1:0]   x10_shr;
	logic signed [TEMP_W-1:0]  tenths_next;
	logic                      clip;
	logic [CLAMP_W-1:0]        clamped;
	logic [HUND_W-1:0]         hund_prod;
	logic [DIGIT_W-1:0]        hund_d;
	logic [REM_W-1:0]          rem_h;
	logic [TENS_W-1:0]         tens_prod;
	logic [DIGIT_W-1:0]        tens_d;
	logic [DIGIT_W-1:0]        unit_d;
	logic                      load;

	assign job_pop    = (state_q == ST_IDLE) && job_ready;
	assign load       = (state_q == ST_DIGIT) && (!res_valid_q || temp.ready);
	assign temp.valid = res_valid_q;
	assign temp.data  = res_q;

	// acc * 10 truncated toward zero, then saturated
	always_comb begin
		acc_ext    = TEN_W'(acc_q);
		x10        = (acc_ext <<< 3) + (acc_ext <<< 1);
		x10_biased = x10 + (x10[TEN_W-1] ? TEN_W'((1 << FRAC_W) - 1) : TEN_W'(0));
		x10_shr    = x10_biased >>> FRAC_W;
		if (x10_shr < $signed(TEN_W'(TENTHS_MIN))) begin
			tenths_next = TEMP_W'(TENTHS_MIN);
		end else if (x10_shr > $signed(TEN_W'(TENTHS_MAX))) begin
			tenths_next = TEMP_W'(TENTHS_MAX);
		end else begin
			tenths_next = x10_shr[TEMP_W-1:0];
		end
	end

	// clamp to the display range, split by reciprocal multiplies
	always_comb begin
		priority if (tenths_q < $signed(TEMP_W'(0))) begin
			clamped = '0;
			clip    = 1'b1;
		end else if (tenths_q > $signed(TEMP_W'(DISP_MAX))) begin
			clamped = CLAMP_W'(DISP_MAX);
			clip    = 1'b1;
		end else begin
			clamped = tenths_q[CLAMP_W-1:0];
			clip    = 1'b0;
		end
		hund_prod = HUND_W'(clamped) * HUND_W'(41);
		hund_d    = hund_prod[12 +: DIGIT_W];
		rem_h     = REM_W'(HUND_W'(clamped) - HUND_W'(hund_d) * HUND_W'(100));
		tens_prod = TENS_W'(rem_h) * TENS_W'(205);
		tens_d    = tens_prod[11 +: DIGIT_W];
		unit_d    = DIGIT_W'(rem_h - REM_W'(tens_d) * REM_W'(10));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_ready) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					state_q <= (k_q == '0) ? ST_TENTH : ST_MUL;
				end
				ST_TENTH: state_q <= ST_DIGIT;
				ST_DIGIT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (temp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			avg_q   <= job.avg;
			volts_q <= job.volts;
			acc_q   <= POLY_COEF[POLY_DEG];
			k_q     <= 3'(POLY_DEG - 1);
		end
		if (state_q == ST_MUL) begin
			prod_q <= MPROD_W'(acc_q) * $signed({1'b0, volts_q});
		end
		if (state_q == ST_ADD) begin
			// arithmetic shift floors toward minus infinity
			acc_q <= ACC_W'(prod_q >>> FRAC_W) + POLY_COEF[k_q];
			if (k_q != '0) begin
				k_q <= k_q - 1'b1;
			end
		end
		if (state_q == ST_TENTH) begin
			tenths_q <= tenths_next;
		end
		if (load) begin
			res_q.averaged_sample <= avg_q;
			res_q.temp_tenths     <= tenths_q;
			res_q.tens_digit      <= hund_d;
			res_q.units_digit     <= tens_d;
			res_q.tenths_digit    <= unit_d;
			res_q.display_clamped <= clip;
		end
	end

	a_tenths_range: assert property (@(posedge clk) disable iff (!arst_n)
		temp.valid |-> (temp.data.temp_tenths >= $signed(TEMP_W'(TENTHS_MIN)) &&
			temp.data.temp_tenths <= $signed(TEMP_W'(TENTHS_MAX))))
		else $error("temperature outside saturation range");

	a_clamp_flag: assert property (@(posedge clk) disable iff (!arst_n)
		temp.valid |-> (temp.data.display_clamped ==
			(temp.data.temp_tenths < $signed(TEMP_W'(0)) ||
			temp.data.temp_tenths > $signed(TEMP_W'(DISP_MAX)))))
		else $error("clamp flag disagrees with temperature");

endmodule
`default_nettype wire

FILE: hdl/thermistor_average_linearize_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_average_linearize_top: thermistor reading to display temperature
// moving average, volts scaling, degree-6 linearization and digit split
// ----------------------------------------------------------------------------
// Each word on adc carries one 10-bit converter reading. The block keeps the
// last WINDOW readings in a ring (zero after reset) with their running sum and
// returns exactly one word on temp per reading: the truncated average, the
// temperature in tenths of a degree (saturated to -1000..2000) and three
// display digits of that value clamped to 0..999, with a flag when clamping
// took place. The front takes a new reading only once it has read the ring,
// updated the sum, run two reciprocal divides and pushed its job, and it
// waits while the queue is full. The back takes one job at a time: the Horner
// loop shares one multiplier over six multiply/add steps, followed by the
// tenths and digit stages. A two-entry queue sits between front and back, and
// the result sits in an output register, so a new reading can be taken while
// a result still waits on temp.ready.
// ----------------------------------------------------------------------------
module thermistor_average_linearize_top #(
	parameter int WINDOW = tal_pkg::WINDOW_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tal_stream_if.sink   adc,
	tal_stream_if.source temp
);
	import tal_pkg::*;

	// front to queue
	logic     job_valid;
	tal_job_t job_in;
	logic     queue_full;

	// queue to back
	logic     queue_empty;
	logic     job_pop;
	tal_job_t job_head;

	// averaging and volts scaling
	tal_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adc       (adc),
		.job_valid (job_valid),
		.job       (job_in),
		.queue_full(queue_full)
	);

	// decouples the two halves
	tal_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_valid),
		.push_job(job_in),
		.full    (queue_full),
		.pop     (job_pop),
		.empty   (queue_empty),
		.head    (job_head)
	);

	// polynomial, tenths and digits, holds the result register
	tal_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_ready(!queue_empty),
		.job      (job_head),
		.job_pop  (job_pop),
		.temp     (temp)
	);

endmodule
`default_nettype wire

FILE: verif/thermistor_average_linearize_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_average_linearize_checker: temperature word predictor and scoreboard
// mirrors the sample ring, average, volts scaling and Horner linearization,
// queues one predicted word per accepted reading and compares every result
// ----------------------------------------------------------------------------
module thermistor_average_linearize_checker #(
	parameter int WINDOW = tal_pkg::WINDOW_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adc_valid,
	input  wire logic              adc_ready,
	input  wire tal_pkg::adc_word_t  adc_data,
	input  wire logic              temp_valid,
	input  wire logic              temp_ready,
	input  wire tal_pkg::temp_word_t temp_data,
	output int                     mismatch_total,
	output int                     words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tal_pkg::*;

	localparam longint Q16_SCALE    = 65536;
	localparam longint TENTHS_FLOOR = -1000;
	localparam longint TENTHS_CEIL  = 2000;
	localparam longint SHOWN_MAX    = 999;
	localparam int     AVG_MAX      = 1023;

	// Q16.16 linearizing polynomial, constant term first
	localparam longint HORNER_COEF [7] = '{
		8675656, -12153651, 11027087, -5790171, 1631715, -230870, 12707
	};

	logic [SAMPLE_W-1:0] shadow_ring [WINDOW];
	logic [5:0]          shadow_slot;
	logic [SUM_W-1:0]    shadow_sum;
	int                  avg_now;
	temp_word_t          temp_words_due [$];
	temp_word_t          want;

	// average -> volts -> polynomial -> tenths -> display digits
	function automatic temp_word_t linearize_average(input int avg);
		longint     volts;
		longint     acc;
		longint     tenths;
		longint     shown;
		int         k;
		temp_word_t w;
		volts = (longint'(avg) * 5 * Q16_SCALE) / 1023;
		acc = HORNER_COEF[6];
		for (k = 5; k >= 0; k--)
			acc = ((acc * volts) >>> 16) + HORNER_COEF[k];
		// signed divide truncates toward zero
		tenths = (acc * 10) / Q16_SCALE;
		if (tenths < TENTHS_FLOOR) tenths = TENTHS_FLOOR;
		if (tenths > TENTHS_CEIL) tenths = TENTHS_CEIL;
		shown = tenths;
		w.display_clamped = 1'b0;
		if (shown < 0) begin
			shown = 0;
			w.display_clamped = 1'b1;
		end else if (shown > SHOWN_MAX) begin
			shown = SHOWN_MAX;
			w.display_clamped = 1'b1;
		end
		w.averaged_sample = SAMPLE_W'(avg);
		w.temp_tenths     = TEMP_W'(tenths);
		w.tens_digit      = DIGIT_W'(shown / 100);
		w.units_digit     = DIGIT_W'((shown / 10) % 10);
		w.tenths_digit    = DIGIT_W'(shown % 10);
		return w;
	endfunction

	task automatic flag_field(input string field, input longint exp_v, input longint got_v);
		$display("%0t ns: %s expected %0d, got %0d", $time, field, exp_v, got_v);
		mismatch_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_ring[i]) shadow_ring[i] = '0;
			shadow_slot = '0;
			shadow_sum = '0;
			temp_words_due.delete();
			mismatch_total = 0;
			words_pending = 0;
		end else begin
			if (temp_valid && temp_ready) begin
				if (temp_words_due.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, got avg %0d tenths %0d",
						$time, temp_data.averaged_sample, temp_data.temp_tenths);
					mismatch_total++;
				end else begin
					want = temp_words_due.pop_front();
					if (temp_data.averaged_sample !== want.averaged_sample)
						flag_field("averaged_sample", want.averaged_sample,
							temp_data.averaged_sample);
					if (temp_data.temp_tenths !== want.temp_tenths)
						flag_field("temp_tenths", want.temp_tenths, temp_data.temp_tenths);
					if (temp_data.tens_digit !== want.tens_digit)
						flag_field("tens_digit", want.tens_digit, temp_data.tens_digit);
					if (temp_data.units_digit !== want.units_digit)
						flag_field("units_digit", want.units_digit, temp_data.units_digit);
					if (temp_data.tenths_digit !== want.tenths_digit)
						flag_field("tenths_digit", want.tenths_digit, temp_data.tenths_digit);
					if (temp_data.display_clamped !== want.display_clamped)
						flag_field("display_clamped", want.display_clamped,
							temp_data.display_clamped);
				end
			end
			if (adc_valid && adc_ready) begin
				if (shadow_slot >= WINDOW) shadow_slot = '0;
				shadow_sum = shadow_sum - shadow_ring[shadow_slot] + adc_data.adc_sample;
				shadow_ring[shadow_slot] = adc_data.adc_sample;
				shadow_slot++;
				if (shadow_slot >= WINDOW) shadow_slot = '0;
				avg_now = int'(shadow_sum) / WINDOW;
				if (avg_now > AVG_MAX) avg_now = AVG_MAX;
				temp_words_due.push_back(linearize_average(avg_now));
			end
			words_pending = temp_words_due.size();
		end
	end

endmodule
`default_nettype wire

FILE: verif/thermistor_average_linearize_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_average_linearize_top_test: testbench of the thermistor linearizer
// directed corner readings, then runs of steady and noisy readings in random
// bursts against a stalling receiver; the checker predicts every word
// ----------------------------------------------------------------------------
module thermistor_average_linearize_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tal_pkg::*;

	localparam int WINDOW = WINDOW_DEF;

	// number of readings in the random part
	localparam int RANDOM_READINGS = 450;

	// receiver hold-off: starts this many cycles after reset, long enough
	// for the two-entry queue and the output register to fill up
	localparam int HOLD_AT  = 3000;
	localparam int HOLD_LEN = 400;

	// idle cycles before giving up: well above the hold-off plus a few
	// back-end passes and the longest receiver stall
	localparam int WATCHDOG_LIMIT = 4000;

	// cycles to keep watching after the last expected word, longer
	// than the front plus back latency
	localparam int DRAIN_TAIL = 64;

	// walking ones, walking zeros, alternating bits and the extremes of the reading
	localparam logic [SAMPLE_W-1:0] CORNER_READINGS [24] = '{
		10'h000, 10'h3FF, 10'h155, 10'h2AA,
		10'h001, 10'h002, 10'h004, 10'h008, 10'h010,
		10'h020, 10'h040, 10'h080, 10'h100, 10'h200,
		10'h3FE, 10'h3FD, 10'h3FB, 10'h3F7, 10'h3EF,
		10'h3DF, 10'h3BF, 10'h37F, 10'h2FF, 10'h1FF
	};

	// receiver stall patterns
	typedef enum logic [1:0] {
		SINK_OPEN,     // always ready
		SINK_COIN,     // ready half the time
		SINK_TRICKLE,  // ready one cycle in four
		SINK_COMB      // fixed pattern on the cycle count
	} sink_mode_t;

	logic clk;
	logic arst_n;
	int   mismatch_total;
	int   words_pending;
	int   idle_cycles = 0;
	int   burst_left = 0;

	tal_stream_if #(.payload_t(adc_word_t))  adc_ch ();
	tal_stream_if #(.payload_t(temp_word_t)) temp_ch ();

	thermistor_average_linearize_top #(
		.WINDOW(WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.adc(adc_ch),
		.temp(temp_ch)
	);

	thermistor_average_linearize_checker #(
		.WINDOW(WINDOW)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.adc_valid(adc_ch.valid),
		.adc_ready(adc_ch.ready),
		.adc_data(adc_ch.data),
		.temp_valid(temp_ch.valid),
		.temp_ready(temp_ch.ready),
		.temp_data(temp_ch.data),
		.mismatch_total(mismatch_total),
		.words_pending(words_pending)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// offer one reading, called at a falling edge and returning at one;
	// opens a new burst with a random gap when the current burst is used up
	task automatic offer_reading(input logic [SAMPLE_W-1:0] reading);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			// a quarter of the bursts follow the previous one with no gap
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				adc_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		adc_ch.valid <= 1'b1;
		adc_ch.data.adc_sample <= reading;
		// the word is taken at the first rising edge with ready high
		do @(posedge clk); while (!adc_ch.ready);
		@(negedge clk);
	endtask

	// sender: reset, corner readings, random runs, then drain and verdict
	initial begin
		int sent;
		int run_left;
		int level;
		int jitter;
		int reading;
		arst_n = 1'b0;
		adc_ch.valid = 1'b0;
		adc_ch.data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// the first readings land in a ring still full of zeros, so these
		// also cover the partly filled window
		foreach (CORNER_READINGS[i])
			offer_reading(CORNER_READINGS[i]);

		// runs around one level: long steady runs at the rails drive the
		// average to both ends, where the display clamps high and low
		sent = 0;
		while (sent < RANDOM_READINGS) begin
			run_left = $urandom_range(1, 90);
			case ($urandom_range(0, 5))
				0: level = 0;
				1: level = 1023;
				default: level = $urandom_range(0, 1023);
			endcase
			jitter = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
			while (run_left > 0 && sent < RANDOM_READINGS) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray reading anywhere in the range
					reading = $urandom_range(0, 1023);
				end else begin
					reading = level + int'($urandom_range(0, 2 * jitter)) - jitter;
					if (reading < 0) reading = 0;
					if (reading > 1023) reading = 1023;
				end
				offer_reading(SAMPLE_W'(reading));
				run_left--;
				sent++;
			end
		end
		adc_ch.valid <= 1'b0;

		// wait for every predicted word, then watch for strays
		while (words_pending != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
		if (mismatch_total == 0 && words_pending == 0)
			$display("thermistor_average_linearize_top verification clean");
		else
			$display("thermistor_average_linearize_top verification failed");
		$finish;
	end

	// receiver: random stall patterns in stretches, one long hold-off
	initial begin
		sink_mode_t mode;
		int         mode_left;
		int         cycles_run;
		temp_ch.ready = 1'b0;
		mode = SINK_OPEN;
		mode_left = 0;
		cycles_run = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cycles_run++;
			if (cycles_run == HOLD_AT) begin
				// sender keeps offering while the block backs up
				temp_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				cycles_run += HOLD_LEN;
				mode_left = 0;
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(10, 120);
			end
			mode_left--;
			case (mode)
				SINK_OPEN:    temp_ch.ready <= 1'b1;
				SINK_COIN:    temp_ch.ready <= 1'($urandom_range(0, 1));
				SINK_TRICKLE: temp_ch.ready <= ($urandom_range(0, 3) == 0);
				SINK_COMB:    temp_ch.ready <= (cycles_run % 3 != 0);
			endcase
		end
	end

	// watchdog: ends the run after too long with no word moving either way
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((adc_ch.valid && adc_ch.ready) || (temp_ch.valid && temp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("thermistor_average_linearize_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
`default_nettype wire
